/* hw/rtl/fbc_pkg.sv */
`default_nettype none

package fbc_pkg;

  // Number of Feistel rounds, one cell each
  localparam int ROUND_COUNT = 4;

  localparam int HALF_W    = 16;
  localparam int WORD_W    = 32;
  localparam int KEY_COUNT = 4;
  localparam int KEY_IDX_W = 2;

  // Key register reset values
  localparam logic [HALF_W-1:0] KEY_FIRST_RST  = 16'h0F0F;
  localparam logic [HALF_W-1:0] KEY_SECOND_RST = 16'hAAAA;
  localparam logic [HALF_W-1:0] KEY_THIRD_RST  = 16'h1357;
  localparam logic [HALF_W-1:0] KEY_FOURTH_RST = 16'hBEEF;

  // Configuration register indexes
  typedef enum logic [KEY_IDX_W-1:0] {
    REG_KEY_FIRST  = 2'd0,
    REG_KEY_SECOND = 2'd1,
    REG_KEY_THIRD  = 2'd2,
    REG_KEY_FOURTH = 2'd3
  } reg_index_t;

  // Operation select
  localparam logic FUNC_ENCRYPT = 1'b0;
  localparam logic FUNC_DECRYPT = 1'b1;

  // Data carried from cell to cell
  typedef struct packed {
    logic              func;
    logic [HALF_W-1:0] left;
    logic [HALF_W-1:0] right;
    logic [WORD_W-1:0] pad;
  } stage_t;

  // G(r,k) = ((r ^ k) + ((r << 3) | (r >> 2))) mod 2^16
  function automatic logic [HALF_W-1:0] round_fn(input logic [HALF_W-1:0] r,
                                                 input logic [HALF_W-1:0] k);
    logic [HALF_W-1:0] mix;
    mix = {r[HALF_W-4:0], 3'b000} | {2'b00, r[HALF_W-1:2]};
    return (r ^ k) + mix;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/feistel_block_cipher_32.sv */
`default_nettype none

// 32-bit Feistel block cipher with a per-block pad word. Each transfer on the
// input carries func (0 encrypt, 1 decrypt), data_word and pad_word and yields
// exactly one result_word, in order. Encrypt XORs the pad first and then runs
// the rounds with keys first..fourth; decrypt runs the inverse rounds with the
// keys reversed and XORs the pad last. The rounds form a chain of ROUND_COUNT
// cells, one register each, followed by an output register: a new block is
// taken every cycle while the output side does not stall, and its result_word
// passes through every cell register and then the output register. The four
// 16-bit round keys are written on the cfg port (index 0..3) and should only
// change while no block is in flight.

module feistel_block_cipher_32
  import fbc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [KEY_IDX_W-1:0] cfg_index,
  input  logic [HALF_W-1:0]    cfg_data,
  // input items
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 func,
  input  logic [WORD_W-1:0]    data_word,
  input  logic [WORD_W-1:0]    pad_word,
  // results
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [WORD_W-1:0]    result_word
);

  logic [HALF_W-1:0] keys [KEY_COUNT];

  logic   chain_valid [ROUND_COUNT+1];
  logic   chain_ready [ROUND_COUNT+1];
  stage_t chain_stage [ROUND_COUNT+1];

  stage_t entry_stage;
  logic   res_valid;
  logic   last_ready;
  stage_t last;

  // Key registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      keys[0] <= KEY_FIRST_RST;
      keys[1] <= KEY_SECOND_RST;
      keys[2] <= KEY_THIRD_RST;
      keys[3] <= KEY_FOURTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_index_t'(cfg_index))
        REG_KEY_FIRST:  keys[0] <= cfg_data;
        REG_KEY_SECOND: keys[1] <= cfg_data;
        REG_KEY_THIRD:  keys[2] <= cfg_data;
        REG_KEY_FOURTH: keys[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Chain entry: encrypt whitens with the pad before the rounds
  always_comb begin
    entry_stage.func  = func;
    entry_stage.pad   = pad_word;
    entry_stage.left  = data_word[WORD_W-1:HALF_W];
    entry_stage.right = data_word[HALF_W-1:0];
    if (func == FUNC_ENCRYPT) begin
      entry_stage.left  = data_word[WORD_W-1:HALF_W] ^ pad_word[WORD_W-1:HALF_W];
      entry_stage.right = data_word[HALF_W-1:0] ^ pad_word[HALF_W-1:0];
    end
  end

  assign chain_valid[0] = in_valid;
  assign chain_stage[0] = entry_stage;
  assign in_ready       = chain_ready[0];

  // Round cells
  for (genvar c = 0; c < ROUND_COUNT; c++) begin : g_round
    localparam int EncIdx = c % KEY_COUNT;
    localparam int DecIdx = (ROUND_COUNT - 1 - c) % KEY_COUNT;

    fbc_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (chain_valid[c]),
      .up_ready (chain_ready[c]),
      .up_stage (chain_stage[c]),
      .key_enc  (keys[KEY_IDX_W'(EncIdx)]),
      .key_dec  (keys[KEY_IDX_W'(DecIdx)]),
      .dn_valid (chain_valid[c+1]),
      .dn_ready (chain_ready[c+1]),
      .dn_stage (chain_stage[c+1])
    );
  end

  // Output register: decrypt XORs the pad after the rounds
  assign last       = chain_stage[ROUND_COUNT];
  assign last_ready = !res_valid || out_ready;
  assign chain_ready[ROUND_COUNT] = last_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (last_ready) begin
      res_valid <= chain_valid[ROUND_COUNT];
    end
  end

  always_ff @(posedge clk) begin
    if (chain_valid[ROUND_COUNT] && last_ready) begin
      if (last.func == FUNC_DECRYPT) begin
        result_word <= {last.left, last.right} ^ last.pad;
      end else begin
        result_word <= {last.left, last.right};
      end
    end
  end

  assign out_valid = res_valid;

endmodule

`default_nettype wire

/* hw/rtl/fbc_cell.sv */
`default_nettype none

module fbc_cell
  import fbc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              up_valid,
  output logic              up_ready,
  input  stage_t            up_stage,
  input  logic [HALF_W-1:0] key_enc,
  input  logic [HALF_W-1:0] key_dec,
  output logic              dn_valid,
  input  logic              dn_ready,
  output stage_t            dn_stage
);

  logic              valid;
  stage_t            stage;
  stage_t            stage_next;
  logic [HALF_W-1:0] g_in;
  logic [HALF_W-1:0] g_key;
  logic [HALF_W-1:0] g_out;

  // One round; decrypt runs the inverse round
  always_comb begin
    stage_next = up_stage;
    g_in       = (up_stage.func == FUNC_DECRYPT) ? up_stage.left : up_stage.right;
    g_key      = (up_stage.func == FUNC_DECRYPT) ? key_dec : key_enc;
    g_out      = round_fn(g_in, g_key);
    if (up_stage.func == FUNC_DECRYPT) begin
      stage_next.left  = up_stage.right ^ g_out;
      stage_next.right = up_stage.left;
    end else begin
      stage_next.left  = up_stage.right;
      stage_next.right = up_stage.left ^ g_out;
    end
  end

  assign up_ready = !valid || dn_ready;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      stage <= stage_next;
    end
  end

  assign dn_valid = valid;
  assign dn_stage = stage;

endmodule

`default_nettype wire

/* tb/tb.sv */
`default_nettype none

module tb;
  import fbc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always #6 clk = ~clk;

  // block ports
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [KEY_IDX_W-1:0] cfg_index = '0;
  logic [HALF_W-1:0]    cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic                 func      = FUNC_ENCRYPT;
  logic [WORD_W-1:0]    data_word = '0;
  logic [WORD_W-1:0]    pad_word  = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [WORD_W-1:0]    result_word;

  feistel_block_cipher_32 dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .data_word   (data_word),
    .pad_word    (pad_word),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_word (result_word)
  );

  // local copy of the round keys, tracks every accepted cfg transfer
  logic [HALF_W-1:0] round_keys [KEY_COUNT] =
    '{KEY_FIRST_RST, KEY_SECOND_RST, KEY_THIRD_RST, KEY_FOURTH_RST};

  logic [WORD_W-1:0] result_words_due [$];
  int                mismatch_count = 0;
  int                send_idle_pct  = 0;
  int                stall_pct      = 0;
  int                hold_left      = 0;
  logic              hold_req       = 1'b0;

  // ---------------------------------------------------------------- predictor

  function automatic logic [HALF_W-1:0] mix_half(input logic [HALF_W-1:0] r,
                                                 input logic [HALF_W-1:0] k);
    logic [HALF_W-1:0] spread;
    spread = (r << 3) | (r >> 2);
    return (r ^ k) + spread;
  endfunction

  function automatic logic [WORD_W-1:0] cipher_word(input logic op,
                                                    input logic [WORD_W-1:0] data,
                                                    input logic [WORD_W-1:0] pad);
    logic [HALF_W-1:0] lh;
    logic [HALF_W-1:0] rh;
    logic [HALF_W-1:0] t;
    if (op == FUNC_ENCRYPT) begin
      {lh, rh} = data ^ pad;
      for (int i = 0; i < ROUND_COUNT; i++) begin
        t  = rh;
        rh = lh ^ mix_half(rh, round_keys[i % KEY_COUNT]);
        lh = t;
      end
      return {lh, rh};
    end else begin
      {lh, rh} = data;
      for (int i = ROUND_COUNT - 1; i >= 0; i--) begin
        t  = lh;
        lh = rh ^ mix_half(lh, round_keys[i % KEY_COUNT]);
        rh = t;
      end
      return {lh, rh} ^ pad;
    end
  endfunction

  // --------------------------------------------------------------- drivers

  // one block on the input channel; valid stays up after the transfer
  task automatic send_block(input logic op, input logic [WORD_W-1:0] data,
                            input logic [WORD_W-1:0] pad);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    func      <= op;
    data_word <= data;
    pad_word  <= pad;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    result_words_due = {result_words_due, cipher_word(op, data, pad)};
  endtask

  // stop offering blocks and let the pipeline empty out
  task automatic drain_results();
    in_valid <= 1'b0;
    while (result_words_due.size() != 0) @(posedge clk);
    repeat (ROUND_COUNT + 4) @(posedge clk);
  endtask

  // writes all four keys back to back; only called with nothing in flight
  task automatic load_keys(input logic [HALF_W-1:0] k0, input logic [HALF_W-1:0] k1,
                           input logic [HALF_W-1:0] k2, input logic [HALF_W-1:0] k3);
    logic [HALF_W-1:0] vals [KEY_COUNT];
    vals = '{k0, k1, k2, k3};
    for (int i = 0; i < KEY_COUNT; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_index_t'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      round_keys[i] = vals[i];
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // fresh random keys
  task automatic load_random_keys();
    load_keys(HALF_W'($urandom), HALF_W'($urandom), HALF_W'($urandom),
              HALF_W'($urandom));
  endtask

  // edge-heavy 32-bit values
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return 32'd1 << $urandom_range(31);
      3:       return ~(32'd1 << $urandom_range(31));
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------- receiver

  // long hold-off on the result side, counted here
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req  <= 1'b0;
      hold_left <= 200;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result check and out_ready pacing
  always @(posedge clk) begin
    logic [WORD_W-1:0] want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (result_words_due.size() == 0) begin
          $error("result_word: no result expected, got %h", result_word);
          mismatch_count++;
        end else begin
          want = result_words_due.pop_front();
          if (result_word !== want) begin
            $error("result_word: expected %h, got %h", want, result_word);
            mismatch_count++;
          end
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
    end
  end

  // ------------------------------------------------------------------ tests

  // reset keys: operand extremes, both operations, a round trip
  task automatic test_reset_keys();
    logic [WORD_W-1:0] ct;
    send_block(FUNC_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
    send_block(FUNC_DECRYPT, 32'h0000_0000, 32'h0000_0000);
    send_block(FUNC_ENCRYPT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_block(FUNC_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_block(FUNC_ENCRYPT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_block(FUNC_ENCRYPT, 32'h8000_0001, 32'h5555_AAAA);
    send_block(FUNC_DECRYPT, 32'hAAAA_5555, 32'h8000_0001);
    send_block(FUNC_ENCRYPT, 32'hFFFF_0000, 32'h0000_FFFF);
    ct = cipher_word(FUNC_ENCRYPT, 32'h1234_5678, 32'hCAFE_F00D);
    send_block(FUNC_ENCRYPT, 32'h1234_5678, 32'hCAFE_F00D);
    send_block(FUNC_DECRYPT, ct, 32'hCAFE_F00D);
    drain_results();
  endtask

  // all-zero, all-one and mixed keys
  task automatic test_key_extremes();
    load_keys('0, '0, '0, '0);
    send_block(FUNC_ENCRYPT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_block(FUNC_DECRYPT, 32'h0000_FFFF, 32'hFFFF_0000);
    send_block(FUNC_ENCRYPT, 32'h0001_8000, 32'h0000_0000);
    drain_results();
    load_keys('1, '1, '1, '1);
    send_block(FUNC_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
    send_block(FUNC_DECRYPT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_block(FUNC_ENCRYPT, 32'h7FFF_FFFE, 32'hFFFF_FFFF);
    drain_results();
    load_keys(16'h0000, 16'hFFFF, 16'h8001, 16'h7FFE);
    send_block(FUNC_ENCRYPT, 32'hDEAD_BEEF, 32'h0F0F_F0F0);
    send_block(FUNC_DECRYPT, 32'hDEAD_BEEF, 32'h0F0F_F0F0);
    send_block(FUNC_ENCRYPT, 32'h8000_0000, 32'h0000_0001);
    drain_results();
  endtask

  // random blocks, each draw either a single block or an encrypt/decrypt round trip
  task automatic run_random_blocks(input int count);
    logic [WORD_W-1:0] data;
    logic [WORD_W-1:0] pad;
    logic [WORD_W-1:0] ct;
    int                sent;
    sent = 0;
    while (sent < count) begin
      data = pick_word();
      pad  = pick_word();
      if ($urandom_range(1)) begin
        ct = cipher_word(FUNC_ENCRYPT, data, pad);
        send_block(FUNC_ENCRYPT, data, pad);
        send_block(FUNC_DECRYPT, ct, pad);
        sent += 2;
      end else begin
        send_block(logic'($urandom_range(1)), data, pad);
        sent++;
      end
    end
  endtask

  // four pacing phases, fresh random keys for each
  task automatic test_random_phases();
    int idle_set  [4] = '{0, 83, 0, 19};
    int stall_set [4] = '{0, 0, 83, 19};
    for (int p = 0; p < 4; p++) begin
      load_random_keys();
      send_idle_pct = idle_set[p];
      stall_pct     = stall_set[p];
      run_random_blocks(170);
      drain_results();
    end
    send_idle_pct = 0;
    stall_pct     = 0;
  endtask

  // result side held off while blocks keep coming, so input stalls
  task automatic test_backpressure();
    load_random_keys();
    hold_req = 1'b1;
    run_random_blocks(60);
    drain_results();
  endtask

  // ------------------------------------------------------------------- main

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_keys();
    test_key_extremes();
    test_random_phases();
    test_backpressure();
    if (mismatch_count == 0) begin
      $display("feistel_block_cipher_32 regression: pass");
    end else begin
      $display("feistel_block_cipher_32 regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("feistel_block_cipher_32 regression: fail");
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
hw/rtl/fbc_pkg.sv
hw/rtl/fbc_cell.sv
hw/rtl/feistel_block_cipher_32.sv
tb/tb.sv
